// ===== rtl/fpa_pkg.sv =====
// Package: command codes, widths and pipeline types for the fixed-point ALU.
`default_nettype none
package fpa_pkg;
   localparam int DATA_W = 32;
   localparam int CMD_W = 4;
   localparam int DEFAULT_FRACTION_BITS = 8;
   localparam int MAG_W = 64;

   localparam logic [CMD_W-1:0] CMD_ADD = 4'd0;
   localparam logic [CMD_W-1:0] CMD_SUB = 4'd1;
   localparam logic [CMD_W-1:0] CMD_MUL = 4'd2;
   localparam logic [CMD_W-1:0] CMD_DIV = 4'd3;
   localparam logic [CMD_W-1:0] CMD_CMP = 4'd4;
   localparam logic [CMD_W-1:0] CMD_MIN = 4'd5;
   localparam logic [CMD_W-1:0] CMD_MAX = 4'd6;
   localparam logic [CMD_W-1:0] CMD_INC = 4'd7;
   localparam logic [CMD_W-1:0] CMD_DEC = 4'd8;
   localparam logic [CMD_W-1:0] CMD_FROM_INT = 4'd9;
   localparam logic [CMD_W-1:0] CMD_TO_INT = 4'd10;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic signed [DATA_W-1:0] operand_a;
      logic signed [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic a_greater;
      logic a_less;
      logic a_equal;
      logic divide_by_zero;
   } rsp_type;

   // Flags and simple result carried alongside the divider row.
   typedef struct packed {
      logic is_div;
      logic dz;
      logic neg;
      logic [DATA_W-1:0] simple;
      logic a_greater;
      logic a_less;
      logic a_equal;
   } side_type;
endpackage
`default_nettype wire

// ===== rtl/fpa_if.sv =====
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface fpa_if #(parameter type PAYLOAD_TYPE = logic) (input wire logic clock);
   logic valid;
   logic ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/fpa_cell.sv =====
// One restoring-division cell: consumes one numerator bit per enabled cycle.
`default_nettype none
module fpa_cell (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic enable,
   input  wire logic valid_in,
   input  wire logic [fpa_pkg::MAG_W-1:0] num_in,
   input  wire logic [fpa_pkg::MAG_W:0] rem_in,
   input  wire logic [fpa_pkg::DATA_W-1:0] den_in,
   input  wire logic [fpa_pkg::MAG_W-1:0] quo_in,
   input  wire fpa_pkg::side_type side_in,
   output logic valid_out,
   output logic [fpa_pkg::MAG_W-1:0] num_out,
   output logic [fpa_pkg::MAG_W:0] rem_out,
   output logic [fpa_pkg::DATA_W-1:0] den_out,
   output logic [fpa_pkg::MAG_W-1:0] quo_out,
   output fpa_pkg::side_type side_out
);
   import fpa_pkg::*;
   logic valid_ff;
   logic [MAG_W-1:0] num_ff, quo_ff;
   logic [MAG_W:0] rem_ff, shifted, diff;
   logic [DATA_W-1:0] den_ff;
   side_type side_ff;
   logic take;

   always_comb begin
      shifted = {rem_in[MAG_W-1:0], num_in[MAG_W-1]};
      diff = shifted - {{(MAG_W-DATA_W+1){1'b0}}, den_in};
      take = !diff[MAG_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         num_ff <= {num_in[MAG_W-2:0], 1'b0};
         rem_ff <= take ? diff : shifted;
         quo_ff <= {quo_in[MAG_W-2:0], take};
         den_ff <= den_in;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign num_out = num_ff;
   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;
   assign side_out = side_ff;
endmodule
`default_nettype wire

// ===== rtl/fixed_point_alu_top.sv =====
// Top level: fixed-point ALU with a row of division cells and a multiply stage.
//
//  channel | dir | payload
//  req     | in  | command, operand_a, operand_b
//  rsp     | out | result_value, a_greater, a_less, a_equal, divide_by_zero
//
// One transfer per cycle in, one out, unless the output stalls; a request
// passes stage 0, 64 restoring cells (one numerator bit each) and out_ff.
// Every command runs through the same row so results keep their order.
// The whole row advances only when the output register is free or drained.
// Reset is synchronous and clears only the valid bits.
`default_nettype none
module fixed_point_alu_top #(
   parameter int FRACTION_BITS = fpa_pkg::DEFAULT_FRACTION_BITS
) (
   input wire logic clock,
   input wire logic reset,
   fpa_if.sink req,
   fpa_if.source rsp
);
   import fpa_pkg::*;
   localparam int N = MAG_W;
   localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (FRACTION_BITS - 1);

   logic advance;
   req_type rq;
   // stage 0: multiply and operand prep
   logic s0_valid_ff;
   logic [MAG_W-1:0] s0_num_ff, s0_prod_ff;
   logic [DATA_W-1:0] s0_den_ff;
   logic s0_is_mul_ff;
   side_type s0_side_ff;

   logic signed [DATA_W-1:0] a, b;
   logic [DATA_W-1:0] mag_a, mag_b, simple;
   logic gt, lt, eq;

   assign rq = req.payload;
   assign a = rq.operand_a;
   assign b = rq.operand_b;
   assign mag_a = a[DATA_W-1] ? (~a + 1'b1) : a;
   assign mag_b = b[DATA_W-1] ? (~b + 1'b1) : b;
   assign gt = a > b;
   assign lt = a < b;
   assign eq = a == b;

   always_comb begin
      case (rq.command)
         CMD_ADD: simple = a + b;
         CMD_SUB: simple = a - b;
         CMD_MIN: simple = lt ? a : b;
         CMD_MAX: simple = gt ? a : b;
         CMD_INC: simple = a + 1'b1;
         CMD_DEC: simple = a - 1'b1;
         CMD_FROM_INT: simple = a << FRACTION_BITS;
         CMD_TO_INT: simple = DATA_W'(a >>> FRACTION_BITS);
         default: simple = '0;
      endcase
   end

   logic out_valid_ff;
   assign advance = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req.valid;
      end
      if (advance) begin
         s0_num_ff <= MAG_W'(mag_a) << FRACTION_BITS;
         s0_den_ff <= (rq.command == CMD_DIV) ? mag_b : DATA_W'(1);
         s0_prod_ff <= MAG_W'(mag_a) * MAG_W'(mag_b);
         s0_is_mul_ff <= rq.command == CMD_MUL;
         s0_side_ff.is_div <= (rq.command == CMD_DIV) && (b != 0);
         s0_side_ff.dz <= (rq.command == CMD_DIV) && (b == 0);
         s0_side_ff.neg <= a[DATA_W-1] ^ b[DATA_W-1];
         s0_side_ff.simple <= simple;
         s0_side_ff.a_greater <= gt;
         s0_side_ff.a_less <= lt;
         s0_side_ff.a_equal <= eq;
      end
   end

   // Multiply result rounds at entry; it rides in simple.
   logic [MAG_W-1:0] mq;
   logic [DATA_W-1:0] mres;
   side_type row_side;
   always_comb begin
      mq = (s0_prod_ff + HALF) >> FRACTION_BITS;
      mres = s0_side_ff.neg ? DATA_W'(~mq + 1'b1) : mq[DATA_W-1:0];
      row_side = s0_side_ff;
      if (s0_is_mul_ff) begin
         row_side.simple = mres;
      end
   end

   logic v [N+1];
   logic [MAG_W-1:0] nm [N+1];
   logic [MAG_W:0] rm [N+1];
   logic [DATA_W-1:0] dn [N+1];
   logic [MAG_W-1:0] qo [N+1];
   side_type sd [N+1];

   assign v[0] = s0_valid_ff;
   assign nm[0] = s0_num_ff;
   assign rm[0] = '0;
   assign dn[0] = s0_den_ff;
   assign qo[0] = '0;
   assign sd[0] = row_side;

   for (genvar i = 0; i < N; i++) begin : g_cell
      fpa_cell u_cell (
         .clock(clock), .reset(reset), .enable(advance),
         .valid_in(v[i]), .num_in(nm[i]), .rem_in(rm[i]), .den_in(dn[i]),
         .quo_in(qo[i]), .side_in(sd[i]),
         .valid_out(v[i+1]), .num_out(nm[i+1]), .rem_out(rm[i+1]),
         .den_out(dn[i+1]), .quo_out(qo[i+1]), .side_out(sd[i+1])
      );
   end

   // Round half away from zero: bump when twice the remainder reaches the divisor.
   logic [MAG_W-1:0] dq;
   logic [DATA_W-1:0] dres;
   side_type fs;
   rsp_type out_ff;
   always_comb begin
      fs = sd[N];
      dq = qo[N] + MAG_W'(({rm[N][MAG_W-1:0], 1'b0}) >= {{(MAG_W-DATA_W+1){1'b0}}, dn[N]});
      dres = fs.neg ? DATA_W'(~dq + 1'b1) : dq[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= v[N];
      end
      if (advance) begin
         out_ff.result_value <= fs.is_div ? dres : (fs.dz ? '0 : fs.simple);
         out_ff.a_greater <= fs.a_greater;
         out_ff.a_less <= fs.a_less;
         out_ff.a_equal <= fs.a_equal;
         out_ff.divide_by_zero <= fs.dz;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> $onehot({rsp.payload.a_greater, rsp.payload.a_less, rsp.payload.a_equal}))
      else $error("compare flags not one-hot");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.divide_by_zero |-> rsp.payload.result_value == 0)
      else $error("divide by zero with non-zero result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(out_ff) && out_valid_ff)
      else $error("output changed while stalled");
endmodule
`default_nettype wire

// ===== bench/fixed_point_alu_top_test.sv =====
// Testbench for the fixed-point ALU: random bursty traffic checked against an in-bench predictor.
module fixed_point_alu_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import fpa_pkg::*;

   localparam int FRAC = DEFAULT_FRACTION_BITS;
   localparam int LATENCY = 66;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpa_if #(.PAYLOAD_TYPE(req_type)) req_ch (.clock(clock));
   fpa_if #(.PAYLOAD_TYPE(rsp_type)) rsp_ch (.clock(clock));

   fixed_point_alu_top #(.FRACTION_BITS(FRAC)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   req_type pending_ops[$];
   rsp_type expected_results[$];
   int mismatches = 0;
   bit stimulus_done = 0;

   function automatic logic [63:0] mag64(logic signed [31:0] v);
      logic signed [63:0] w;
      w = v;
      return w < 0 ? -w : w;
   endfunction

   function automatic rsp_type alu_predict(req_type op);
      rsp_type r;
      logic [63:0] m, q, rem, den;
      logic neg;
      r = '0;
      neg = op.operand_a[31] ^ op.operand_b[31];
      case (op.command)
         CMD_ADD: r.result_value = op.operand_a + op.operand_b;
         CMD_SUB: r.result_value = op.operand_a - op.operand_b;
         CMD_MUL: begin
            m = mag64(op.operand_a) * mag64(op.operand_b);
            q = (m + (64'd1 << (FRAC - 1))) >> FRAC;
            r.result_value = neg ? -q[31:0] : q[31:0];
         end
         CMD_DIV: begin
            if (op.operand_b == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               m = mag64(op.operand_a) << FRAC;
               den = mag64(op.operand_b);
               q = m / den;
               rem = m % den;
               if (2 * rem >= den) q = q + 1;
               r.result_value = neg ? -q[31:0] : q[31:0];
            end
         end
         CMD_MIN: r.result_value = (op.operand_a < op.operand_b) ? op.operand_a : op.operand_b;
         CMD_MAX: r.result_value = (op.operand_a > op.operand_b) ? op.operand_a : op.operand_b;
         CMD_INC: r.result_value = op.operand_a + 1;
         CMD_DEC: r.result_value = op.operand_a - 1;
         CMD_FROM_INT: r.result_value = op.operand_a << FRAC;
         CMD_TO_INT: r.result_value = op.operand_a >>> FRAC;
         default: r.result_value = '0;
      endcase
      r.a_greater = op.operand_a > op.operand_b;
      r.a_less = op.operand_a < op.operand_b;
      r.a_equal = op.operand_a == op.operand_b;
      return r;
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 4096)) - 2048) : 32'd1;
         4: return {{16{1'b0}}, 16'($urandom)} ^ ($urandom_range(0, 1) ? '1 : '0);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_op(logic [3:0] c, logic [31:0] a, logic [31:0] b);
      req_type op;
      op.command = c;
      op.operand_a = a;
      op.operand_b = b;
      pending_ops.push_back(op);
   endtask

   initial begin
      logic [31:0] edges[4];
      edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
      for (int c = 0; c < 16; c++) queue_op(c[3:0], edges[c % 4], edges[(c + 1) % 4]);
      queue_op(CMD_DIV, 32'h0000_0300, 32'h0);
      queue_op(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
      queue_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
      queue_op(CMD_CMP, 32'h1234_5678, 32'h1234_5678);
      queue_op(CMD_TO_INT, 32'hffff_ff01, 32'h0);
      queue_op(CMD_ADD, 32'h7fff_ffff, 32'h1);
      for (int i = 0; i < 1400; i++)
         queue_op($urandom_range(0, 9) == 0 ? 4'($urandom_range(11, 15))
                  : 4'($urandom_range(0, 10)), pick_operand(), pick_operand());
      stimulus_done = 1;
   end

   // driver: bursts of transfers separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(alu_predict(req_ch.payload));
            void'(pending_ops.pop_front());
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_ops.size() > (req_ch.valid && req_ch.ready ? 0 : 0)
                         && pending_ops.size() != 0) begin
               req_ch.valid <= 1'b1;
               req_ch.payload <= pending_ops[0];
               if (burst_left == 0) burst_left = $urandom_range(1, 40);
               burst_left--;
               if (burst_left == 0) gap_left = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: stall pattern, compare against the oldest expectation
   int stall_phase = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transfer: %p", rsp_ch.payload);
            end else begin
               want = expected_results.pop_front();
               if (want !== rsp_ch.payload) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", want, rsp_ch.payload);
               end
            end
         end
         stall_phase = (stall_phase + 1) % 200;
         if (stall_phase < 60) rsp_ch.ready <= 1'b1;
         else if (stall_phase < 140) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         else rsp_ch.ready <= (stall_phase % 7) < 3;
      end
   end

   // pending_ops is popped in the driver on transfer, so the first entry is the live one
   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done);
      wait (pending_ops.size() == 0 && !req_ch.valid);
      wait (expected_results.size() == 0);
      repeat (LATENCY * 2) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
